FILE: design/rhss_pkg.sv
// Package for the rolling hash substring search block.
// Widths, register indexes, sequencer states, interface structs and helpers.
// No dependencies.
`default_nettype none

package rhss_pkg;

    localparam int NEEDLE_MAX    = 8;
    localparam int POSITION_BITS = 16;
    localparam int BYTE_W        = 8;
    localparam int HASH_W        = 16;
    localparam int LEN_W         = 4;
    localparam int RADIX_W       = 8;
    localparam int POS_OUT_W     = 16;
    localparam int NEEDLE_W      = NEEDLE_MAX * BYTE_W;
    localparam int IDX_W         = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
    localparam int PROD_W        = BYTE_W + HASH_W;
    localparam int DIFF_W        = HASH_W + BYTE_W + 1;
    localparam int RED_W         = DIFF_W + RADIX_W;
    localparam int RED_CNT_W     = $clog2(RED_W + 1);
    localparam int CFG_IDX_W     = 2;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEEDLE_BYTES,
        CFG_NEEDLE_LENGTH,
        CFG_HASH_RADIX,
        CFG_HASH_MODULUS
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DROP,
        ST_LOAD,
        ST_REDUCE,
        ST_RESULT,
        ST_CFG_INIT,
        ST_CFG_HASH,
        ST_CFG_POWER
    } state_t;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_HASH,
        OP_POWER
    } op_t;

    typedef struct packed {
        logic             start;
        logic [RED_W-1:0] value;
    } red_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } red_stat_t;

    typedef struct packed {
        logic              clear;
        logic              shift;
        logic [BYTE_W-1:0] data;
    } win_ctrl_t;

    function automatic logic [BYTE_W-1:0] needle_byte(
        input logic [NEEDLE_W-1:0] bytes,
        input logic [IDX_W-1:0]    idx
    );
        return bytes[idx*BYTE_W +: BYTE_W];
    endfunction

endpackage

`default_nettype wire

FILE: design/rhss_modred.sv
// Shared modular reduction unit: remainder of a wide value by the modulus,
// one bit per cycle, most significant bit first. Uses rhss_pkg.
`default_nettype none

module rhss_modred
    import rhss_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire red_req_t          req,
    input  wire logic [HASH_W-1:0] modulus,
    output red_stat_t              stat,
    output logic [HASH_W-1:0]      remainder
);

    logic [RED_W-1:0]     value_reg;
    logic [RED_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [HASH_W-1:0]    rem_reg;
    logic [HASH_W:0]      trial;
    logic [HASH_W:0]      rem_next;

    // r < m holds before each step, so 2r + bit < 2m: one subtract suffices
    always_comb
    begin
        trial = {rem_reg, value_reg[RED_W-1]};
        if (trial >= {1'b0, modulus})
        begin
            rem_next = trial - {1'b0, modulus};
        end
        else
        begin
            rem_next = trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= RED_CNT_W'(RED_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - RED_CNT_W'(1);
            if (cnt_reg == RED_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            value_reg <= req.value;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            value_reg <= {value_reg[RED_W-2:0], 1'b0};
            rem_reg   <= rem_next[HASH_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: design/rhss_window.sv
// Window of the most recent text bytes, entry 0 newest, with oldest-byte
// select and byte-wise needle compare. Uses rhss_pkg.
`default_nettype none

module rhss_window
    import rhss_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire win_ctrl_t           ctrl,
    input  wire logic [NEEDLE_W-1:0] needle_bytes,
    input  wire logic [LEN_W-1:0]    len_eff,
    output logic [BYTE_W-1:0]        oldest,
    output logic                     bytes_equal
);

    logic [BYTE_W-1:0]     recent_reg [NEEDLE_MAX];
    logic [NEEDLE_MAX-1:0] lane_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NEEDLE_MAX; i++)
            begin
                recent_reg[i] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < NEEDLE_MAX; i++)
            begin
                recent_reg[i] <= '0;
            end
        end
        else if (ctrl.shift)
        begin
            recent_reg[0] <= ctrl.data;
            for (int i = 1; i < NEEDLE_MAX; i++)
            begin
                recent_reg[i] <= recent_reg[i-1];
            end
        end
    end

    assign oldest = recent_reg[IDX_W'(len_eff - LEN_W'(1))];

    // newest window byte lines up with the last needle byte
    always_comb
    begin
        for (int i = 0; i < NEEDLE_MAX; i++)
        begin
            if (LEN_W'(i) < len_eff)
            begin
                lane_ok[i] = recent_reg[i] == needle_byte(needle_bytes,
                             IDX_W'(len_eff - LEN_W'(1) - LEN_W'(i)));
            end
            else
            begin
                lane_ok[i] = 1'b1;
            end
        end
        bytes_equal = &lane_ok;
    end

endmodule

`default_nettype wire

FILE: design/rolling_hash_substring_search.sv
// Rolling hash substring search: first needle match in a byte stream.
// A byte is taken only in the idle state, so a new byte waits until the last one is through,
// held up by the 33-step serial modular reduction of each byte before a text's result.
// Bytes after a text's result skip the reduction. A config write runs len hash and len-1
// power reductions before ready returns.
// Reset: async, active low; registers to defaults, derived hashes preset, no sweep.
`default_nettype none

module rolling_hash_substring_search
    import rhss_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [BYTE_W-1:0]    s_axis_tdata,   // [7:0] text_byte
    input  wire logic                 s_axis_tuser,   // [0] text_first
    input  wire logic                 s_axis_tlast,   // text_last
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [POS_OUT_W-1:0]      m_axis_tdata,   // [15:0] match_position
    output logic                      m_axis_tuser,   // [0] found
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [NEEDLE_W-1:0]  cfg_data
);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   op_we;

    logic [NEEDLE_W-1:0]      needle_bytes_reg;
    logic [LEN_W-1:0]         needle_length_reg;
    logic [RADIX_W-1:0]       hash_radix_reg;
    logic [HASH_W-1:0]        hash_modulus_reg;
    logic [HASH_W-1:0]        window_hash_reg;
    logic [HASH_W-1:0]        needle_hash_reg;
    logic [HASH_W-1:0]        leading_power_reg;
    logic [POSITION_BITS-1:0] bytes_seen_reg;
    logic                     search_done_reg;
    logic [BYTE_W-1:0]        byte_reg;
    logic                     last_reg;
    logic [PROD_W-1:0]        drop_reg;
    logic [LEN_W-1:0]         iter_reg;
    logic                     out_valid_reg;
    logic                     out_found_reg;
    logic [POS_OUT_W-1:0]     out_pos_reg;

    logic [LEN_W-1:0]  len_eff;
    logic [HASH_W-1:0] mod_eff;
    logic              enough_bytes;
    logic              match;
    logic              res_needed;
    logic              out_blocked;
    logic [DIFF_W-1:0] v_diff;
    logic [RED_W-1:0]  v_byte;
    logic [RED_W-1:0]  v_hash;
    logic [RED_W-1:0]  v_power;
    logic [POSITION_BITS-1:0] pos_value;

    logic in_xfer, cfg_xfer;
    logic drop_load, byte_update, res_fire;
    logic cfg_init, hash_store, power_store, iter_inc, iter_set1;

    red_req_t          red_req;
    red_stat_t         red_stat;
    logic [HASH_W-1:0] red_rem;
    win_ctrl_t         win_ctrl;
    logic [BYTE_W-1:0] oldest;
    logic              bytes_equal;

    rhss_modred u_modred (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (red_req),
        .modulus   (mod_eff),
        .stat      (red_stat),
        .remainder (red_rem)
    );

    rhss_window u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (win_ctrl),
        .needle_bytes (needle_bytes_reg),
        .len_eff      (len_eff),
        .oldest       (oldest),
        .bytes_equal  (bytes_equal)
    );

    always_comb
    begin
        if (needle_length_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (needle_length_reg > LEN_W'(NEEDLE_MAX))
        begin
            len_eff = LEN_W'(NEEDLE_MAX);
        end
        else
        begin
            len_eff = needle_length_reg;
        end
        mod_eff = (hash_modulus_reg < HASH_W'(2)) ? HASH_W'(1) : hash_modulus_reg;
    end

    assign enough_bytes = bytes_seen_reg >= POSITION_BITS'(len_eff);
    assign match        = enough_bytes && (window_hash_reg == needle_hash_reg) && bytes_equal;
    assign res_needed   = match || last_reg;
    assign out_blocked  = out_valid_reg && !m_axis_tready;
    assign pos_value    = (bytes_seen_reg == POS_MAX) ? POS_MAX
                        : bytes_seen_reg - POSITION_BITS'(len_eff);

    // window update, stale oldest term removed with a multiple of the modulus added
    // so that the difference stays positive: (wh + 256m - oldest*lp)*R + b
    always_comb
    begin
        v_diff  = DIFF_W'(window_hash_reg) + DIFF_W'({mod_eff, 8'b0}) - DIFF_W'(drop_reg);
        v_byte  = RED_W'(v_diff) * RED_W'(hash_radix_reg) + RED_W'(byte_reg);
        v_hash  = RED_W'(needle_hash_reg) * RED_W'(hash_radix_reg)
                + RED_W'(needle_byte(needle_bytes_reg, IDX_W'(iter_reg)));
        v_power = RED_W'(leading_power_reg) * RED_W'(hash_radix_reg);
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready     = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_xfer      = cfg_valid && cfg_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_xfer)
                begin
                    state_next = ST_CFG_INIT;
                end
                else if (in_xfer)
                begin
                    state_next = ST_DROP;
                end
            end
            ST_DROP:
            begin
                state_next = search_done_reg ? ST_IDLE : ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                if (red_stat.done)
                begin
                    case (op_reg)
                        OP_HASH:  state_next = ST_CFG_HASH;
                        OP_POWER: state_next = ST_CFG_POWER;
                        default:  state_next = ST_RESULT;
                    endcase
                end
            end
            ST_RESULT:
            begin
                if (!(res_needed && out_blocked))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CFG_INIT:
            begin
                state_next = ST_CFG_HASH;
            end
            ST_CFG_HASH:
            begin
                state_next = (iter_reg < len_eff) ? ST_REDUCE : ST_CFG_POWER;
            end
            ST_CFG_POWER:
            begin
                state_next = (iter_reg < len_eff) ? ST_REDUCE : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        red_req       = '0;
        win_ctrl      = '0;
        win_ctrl.data = byte_reg;
        op_next       = OP_BYTE;
        op_we         = 1'b0;
        drop_load     = 1'b0;
        byte_update   = 1'b0;
        res_fire      = 1'b0;
        cfg_init      = 1'b0;
        hash_store    = 1'b0;
        power_store   = 1'b0;
        iter_inc      = 1'b0;
        iter_set1     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                win_ctrl.clear = in_xfer && s_axis_tuser && !cfg_xfer;
            end
            ST_DROP:
            begin
                drop_load = !search_done_reg;
            end
            ST_LOAD:
            begin
                red_req.start = 1'b1;
                red_req.value = v_byte;
                op_next       = OP_BYTE;
                op_we         = 1'b1;
            end
            ST_REDUCE:
            begin
                if (red_stat.done)
                begin
                    case (op_reg)
                        OP_HASH:
                        begin
                            hash_store = 1'b1;
                            iter_inc   = 1'b1;
                        end
                        OP_POWER:
                        begin
                            power_store = 1'b1;
                            iter_inc    = 1'b1;
                        end
                        default:
                        begin
                            byte_update    = 1'b1;
                            win_ctrl.shift = 1'b1;
                        end
                    endcase
                end
            end
            ST_RESULT:
            begin
                res_fire = res_needed && !out_blocked;
            end
            ST_CFG_INIT:
            begin
                cfg_init = 1'b1;
            end
            ST_CFG_HASH:
            begin
                if (iter_reg < len_eff)
                begin
                    red_req.start = 1'b1;
                    red_req.value = v_hash;
                    op_next       = OP_HASH;
                    op_we         = 1'b1;
                end
                else
                begin
                    iter_set1 = 1'b1;
                end
            end
            ST_CFG_POWER:
            begin
                if (iter_reg < len_eff)
                begin
                    red_req.start = 1'b1;
                    red_req.value = v_power;
                    op_next       = OP_POWER;
                    op_we         = 1'b1;
                end
            end
            default:
            begin
                red_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            op_reg            <= OP_BYTE;
            needle_bytes_reg  <= '0;
            needle_length_reg <= LEN_W'(1);
            hash_radix_reg    <= RADIX_W'(10);
            hash_modulus_reg  <= HASH_W'(31);
            needle_hash_reg   <= '0;
            leading_power_reg <= HASH_W'(1);
            window_hash_reg   <= '0;
            bytes_seen_reg    <= '0;
            search_done_reg   <= 1'b0;
            iter_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (op_we)
            begin
                op_reg <= op_next;
            end

            if (cfg_xfer)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_NEEDLE_BYTES:  needle_bytes_reg  <= cfg_data;
                    CFG_NEEDLE_LENGTH: needle_length_reg <= cfg_data[LEN_W-1:0];
                    CFG_HASH_RADIX:    hash_radix_reg    <= cfg_data[RADIX_W-1:0];
                    CFG_HASH_MODULUS:  hash_modulus_reg  <= cfg_data[HASH_W-1:0];
                    default:           needle_bytes_reg  <= needle_bytes_reg;
                endcase
            end

            if (cfg_init)
            begin
                needle_hash_reg   <= '0;
                leading_power_reg <= (mod_eff == HASH_W'(1)) ? '0 : HASH_W'(1);
                iter_reg          <= '0;
            end
            else if (iter_set1)
            begin
                iter_reg <= LEN_W'(1);
            end
            else if (iter_inc)
            begin
                iter_reg <= iter_reg + LEN_W'(1);
            end

            if (hash_store)
            begin
                needle_hash_reg <= red_rem;
            end
            if (power_store)
            begin
                leading_power_reg <= red_rem;
            end

            if (win_ctrl.clear)
            begin
                window_hash_reg <= '0;
                bytes_seen_reg  <= '0;
                search_done_reg <= 1'b0;
            end
            else if (byte_update)
            begin
                window_hash_reg <= red_rem;
                if (bytes_seen_reg != POS_MAX)
                begin
                    bytes_seen_reg <= bytes_seen_reg + POSITION_BITS'(1);
                end
            end
            else if (res_fire)
            begin
                search_done_reg <= 1'b1;
            end

            if (res_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            byte_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
        if (drop_load)
        begin
            drop_reg <= enough_bytes ? PROD_W'(oldest) * PROD_W'(leading_power_reg) : '0;
        end
        if (res_fire)
        begin
            out_found_reg <= match;
            out_pos_reg   <= match ? POS_OUT_W'(pos_value) : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = out_pos_reg;

endmodule

`default_nettype wire

FILE: design/rhss_checker.sv
// Port-level checks for rolling_hash_substring_search, attached by bind.
// Uses rhss_pkg.
`default_nettype none

module rhss_checker
    import rhss_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [POS_OUT_W-1:0] m_axis_tdata,
    input wire logic                 m_axis_tuser,
    input wire logic                 cfg_valid,
    input wire logic                 cfg_ready
);

    // byte intake only while config is also open
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> cfg_ready)
        else $error("s_axis_tready without cfg_ready");

    // a byte transfer occupies the sequencer
    a_busy_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (!s_axis_tready && !cfg_ready))
        else $error("ready after byte transfer");

    // a config write starts the needle hash derivation
    a_busy_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (!cfg_ready && !s_axis_tready))
        else $error("ready after config transfer");

    a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("nonzero position without match");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind rolling_hash_substring_search rhss_checker u_rhss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);

`default_nettype wire
